// ===== design/lsqn_pkg.sv =====
// shared types and constants for the latin square squaring normaliser
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package lsqn_pkg;
    localparam int ELEM_W = 16;
    localparam int PROD_W = 35;
    localparam int DIFF_W = 36;
    localparam int NORM_W = 16;
    localparam int IDX_W  = 3;
    localparam int LEN_W  = 4;

    typedef struct packed {
        logic wr_b;
        logic clr;
        logic step;
        logic wr_norm;
    } t_cell_ctrl;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MAC  = 5'b00010,
        S_SCAN = 5'b00100,
        S_DIV  = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;
endpackage
`default_nettype wire

// ===== design/lsqn_cell.sv =====
// one ring cell: holds a vector element, a lag accumulator and its normalised value
// depends on lsqn_pkg
`timescale 1ns / 1ps
`default_nettype none
module lsqn_cell
    import lsqn_pkg::*;
(
    input  wire                      i_clk,
    input  t_cell_ctrl               i_ctrl,
    input  wire                      i_sel,
    input  wire signed [ELEM_W-1:0]  i_elem,
    input  wire signed [ELEM_W-1:0]  i_bcast,
    input  wire signed [ELEM_W-1:0]  i_next_b,
    input  wire        [NORM_W-1:0]  i_norm,
    output logic signed [ELEM_W-1:0] o_b,
    output logic signed [PROD_W-1:0] o_acc,
    output logic        [NORM_W-1:0] o_norm
);
    logic signed [ELEM_W-1:0]   r_b;
    logic signed [PROD_W-1:0]   r_acc;
    logic        [NORM_W-1:0]   r_norm;
    logic signed [2*ELEM_W-1:0] w_mul;

    assign w_mul = i_bcast * r_b;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_b && i_sel) begin
            r_b <= i_elem;
        end else if (i_ctrl.step) begin
            r_b <= i_next_b;
        end
        if (i_ctrl.clr) begin
            r_acc <= '0;
        end else if (i_ctrl.step) begin
            r_acc <= r_acc + PROD_W'(w_mul);
        end
        if (i_ctrl.wr_norm && i_sel) begin
            r_norm <= i_norm;
        end
    end

    assign o_b    = r_b;
    assign o_acc  = r_acc;
    assign o_norm = r_norm;
endmodule
`default_nettype wire

// ===== design/lsqn_div.sv =====
// restoring divider, one quotient bit per cycle, floor(diff * 2^15 / span)
// depends on lsqn_pkg
`timescale 1ns / 1ps
`default_nettype none
module lsqn_div
    import lsqn_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  wire  [DIFF_W-1:0] i_diff,
    input  wire  [DIFF_W-1:0] i_span,
    output logic              o_done,
    output logic [NORM_W-1:0] o_quot
);
    logic [DIFF_W:0]   r_rem;
    logic [DIFF_W-1:0] r_span;
    logic [NORM_W-1:0] r_q;
    logic [3:0]        r_bit;
    logic              r_run;
    logic              r_done;
    logic              w_ge;
    logic [DIFF_W:0]   w_sub;

    assign w_ge  = r_rem >= {1'b0, r_span};
    assign w_sub = w_ge ? (r_rem - {1'b0, r_span}) : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && r_bit == 4'd15) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_rem  <= {1'b0, i_diff};
            r_span <= i_span;
            r_bit  <= '0;
        end else if (r_run) begin
            r_rem <= {w_sub[DIFF_W-1:0], 1'b0};
            r_q   <= {r_q[NORM_W-2:0], w_ge};
            r_bit <= r_bit + 4'd1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule
`default_nettype wire

// ===== design/latin_square_square_normalizer_top.sv =====
// sequence: n load beats, mac ring steps, a min/max scan, one division per lag
// (none if all lags are equal), then n*n result beats; one vector at a time
// throughput is set by the shared serial divider and the ring of n mac cells
// input is stalled from the last element until the final result beat is taken,
// and while a length write is offered
// synchronous active-low reset: length 8, load count zero, output empty
`timescale 1ns / 1ps
`default_nettype none
module latin_square_square_normalizer_top
    import lsqn_pkg::*;
#(
    parameter int MAX_LENGTH = 8
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire        [LEN_W-1:0]   i_cfg_data,
    input  wire                      i_valid,
    output logic                     o_stall,
    input  wire signed [ELEM_W-1:0]  i_element,
    output logic                     o_valid,
    input  wire                      i_stall,
    output logic       [IDX_W-1:0]   o_row,
    output logic       [IDX_W-1:0]   o_col,
    output logic signed [PROD_W-1:0] o_product,
    output logic       [NORM_W-1:0]  o_normalized,
    output logic                     o_skipped,
    output logic                     o_last
);
    t_state                   r_state;
    logic [LEN_W-1:0]         r_len;
    logic [LEN_W-1:0]         r_load_cnt;
    logic [LEN_W-1:0]         r_cnt;
    logic signed [PROD_W-1:0] r_lo, r_hi;
    logic                     r_skip, r_div_busy;
    logic [IDX_W-1:0]         r_row, r_col;
    logic                     r_ov;

    logic [LEN_W-1:0]         w_n;
    logic [LEN_W-1:0]         w_nm1;
    logic                     w_in_acc, w_out_free;
    t_cell_ctrl               w_ctrl;
    logic [IDX_W-1:0]         w_rd_idx;
    logic [LEN_W-1:0]         w_lag;
    logic signed [PROD_W-1:0] w_acc_sel;
    logic [NORM_W-1:0]        w_norm_sel;
    logic signed [ELEM_W-1:0] w_b   [MAX_LENGTH];
    logic signed [PROD_W-1:0] w_acc [MAX_LENGTH];
    logic [NORM_W-1:0]        w_nrm [MAX_LENGTH];
    logic                     w_div_start, w_div_done;
    logic [NORM_W-1:0]        w_quot;
    logic [DIFF_W-1:0]        w_diff, w_span;

    assign w_n = (r_len == '0) ? LEN_W'(1) :
                 (r_len > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : r_len;
    assign w_nm1 = w_n - LEN_W'(1);

    assign o_cfg_ready = (r_state == S_IDLE) && !r_ov;
    assign o_stall     = (r_state != S_IDLE) || r_ov || i_cfg_valid;
    assign w_in_acc    = i_valid && !o_stall;
    assign w_out_free  = !r_ov || !i_stall;

    always_comb begin
        w_ctrl         = '0;
        w_ctrl.wr_b    = w_in_acc;
        w_ctrl.clr     = w_in_acc && (r_load_cnt == w_nm1);
        w_ctrl.step    = (r_state == S_MAC);
        w_ctrl.wr_norm = (r_state == S_DIV) && w_div_done;
    end

    // lag of cell (row, col) is (col - row) mod n
    assign w_lag = (r_col >= r_row) ? LEN_W'(r_col) - LEN_W'(r_row)
                                    : LEN_W'(r_col) + w_n - LEN_W'(r_row);
    assign w_rd_idx = (r_state == S_EMIT) ? w_lag[IDX_W-1:0] : r_cnt[IDX_W-1:0];

    always_comb begin
        w_acc_sel  = w_acc[0];
        w_norm_sel = w_nrm[0];
        for (int c = 0; c < MAX_LENGTH; c++) begin
            if (w_rd_idx == IDX_W'(c)) begin
                w_acc_sel  = w_acc[c];
                w_norm_sel = w_nrm[c];
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_LENGTH; g++) begin : g_cell
            logic signed [ELEM_W-1:0] w_next;
            logic                     w_sel;
            if (g + 1 < MAX_LENGTH) begin : g_mid
                assign w_next = (w_nm1 == LEN_W'(g)) ? w_b[0] : w_b[g+1];
            end else begin : g_end
                assign w_next = w_b[0];
            end
            assign w_sel = (r_state == S_IDLE) ? (r_load_cnt == LEN_W'(g))
                                               : (r_cnt == LEN_W'(g));
            lsqn_cell u_cell (
                .i_clk    (i_clk),
                .i_ctrl   (w_ctrl),
                .i_sel    (w_sel),
                .i_elem   (i_element),
                .i_bcast  (w_b[0]),
                .i_next_b (w_next),
                .i_norm   (w_quot),
                .o_b      (w_b[g]),
                .o_acc    (w_acc[g]),
                .o_norm   (w_nrm[g])
            );
        end
    endgenerate

    assign w_diff = DIFF_W'($signed({w_acc_sel[PROD_W-1], w_acc_sel})
                            - $signed({r_lo[PROD_W-1], r_lo}));
    assign w_span = DIFF_W'($signed({r_hi[PROD_W-1], r_hi})
                            - $signed({r_lo[PROD_W-1], r_lo}));
    assign w_div_start = (r_state == S_DIV) && !r_div_busy && (r_lo != r_hi);

    lsqn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_diff  (w_diff),
        .i_span  (w_span),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_len      <= LEN_W'(8);
            r_load_cnt <= '0;
            r_cnt      <= '0;
            r_div_busy <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_len      <= i_cfg_data;
                r_load_cnt <= '0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (r_load_cnt == w_nm1) begin
                            r_load_cnt <= '0;
                            r_cnt      <= '0;
                            r_state    <= S_MAC;
                        end else begin
                            r_load_cnt <= r_load_cnt + LEN_W'(1);
                        end
                    end
                end
                S_MAC: begin
                    if (r_cnt == w_nm1) begin
                        r_cnt   <= '0;
                        r_state <= S_SCAN;
                    end else begin
                        r_cnt <= r_cnt + LEN_W'(1);
                    end
                end
                S_SCAN: begin
                    if (r_cnt == '0) begin
                        r_lo <= w_acc_sel;
                        r_hi <= w_acc_sel;
                    end else begin
                        if (w_acc_sel < r_lo) r_lo <= w_acc_sel;
                        if (w_acc_sel > r_hi) r_hi <= w_acc_sel;
                    end
                    r_skip <= 1'b0;
                    if (r_cnt == w_nm1) begin
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt + LEN_W'(1);
                    end
                end
                S_DIV: begin
                    if (r_lo == r_hi) begin
                        r_skip  <= 1'b1;
                        r_row   <= '0;
                        r_col   <= '0;
                        r_state <= S_EMIT;
                    end else if (w_div_start) begin
                        r_div_busy <= 1'b1;
                    end else if (w_div_done) begin
                        r_div_busy <= 1'b0;
                        if (r_cnt == w_nm1) begin
                            r_row   <= '0;
                            r_col   <= '0;
                            r_state <= S_EMIT;
                        end else begin
                            r_cnt <= r_cnt + LEN_W'(1);
                        end
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        if (LEN_W'(r_col) == w_nm1) begin
                            r_col <= '0;
                            if (LEN_W'(r_row) == w_nm1) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_row <= r_row + IDX_W'(1);
                            end
                        end else begin
                            r_col <= r_col + IDX_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (r_state == S_EMIT && w_out_free) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
        if (r_state == S_EMIT && w_out_free) begin
            o_row        <= r_row;
            o_col        <= r_col;
            o_product    <= w_acc_sel;
            o_normalized <= r_skip ? '0 : w_norm_sel;
            o_skipped    <= r_skip;
            o_last       <= (LEN_W'(r_col) == w_nm1) && (LEN_W'(r_row) == w_nm1);
        end
    end

    assign o_valid = r_ov;
endmodule
`default_nettype wire

// ===== design/lsqn_checker.sv =====
// port-level checks on result channel and o_stall, bound to top
// depends on lsqn_pkg and latin_square_square_normalizer_top
`timescale 1ns / 1ps
`default_nettype none
module lsqn_checker
    import lsqn_pkg::*;
(
    input wire                      i_clk,
    input wire                      i_rst_n,
    input wire                      o_stall,
    input wire                      o_valid,
    input wire                      i_stall,
    input wire signed [PROD_W-1:0]  o_product,
    input wire        [NORM_W-1:0]  o_normalized,
    input wire                      o_skipped
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result beat dropped while stalled");
    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_product))
        else $error("stalled product changed");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while results pending");
    a_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_skipped |-> o_normalized == '0)
        else $error("skipped beat with nonzero fraction");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_normalized <= 16'd32768)
        else $error("fraction above one");
endmodule

bind latin_square_square_normalizer_top lsqn_checker u_lsqn_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_product    (o_product),
    .o_normalized (o_normalized),
    .o_skipped    (o_skipped)
);
`default_nettype wire

// ===== test/latin_square_square_normalizer_top_test.sv =====
// testbench for the latin square squaring normaliser: directed table then random vectors,
// every result beat checked against an in-bench model of the squared latin square
// depends on lsqn_pkg and latin_square_square_normalizer_top
`timescale 1ns / 1ps
module latin_square_square_normalizer_top_test;
    import lsqn_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [PROD_W-1:0] product;
        logic [NORM_W-1:0]        normalized;
        logic                     skipped;
        logic                     last;
    } t_cell;

    typedef struct {
        logic [LEN_W-1:0]  len;     // length written before this row's element
        logic              do_len;
        logic signed [15:0] elem;
        logic              known;   // expected first cell typed in
        logic signed [PROD_W-1:0] p00;
        logic              skip00;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [LEN_W-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic signed [ELEM_W-1:0] i_element = '0;
    logic i_stall = 1'b0;
    wire o_cfg_ready, o_stall, o_valid, o_skipped, o_last;
    wire [IDX_W-1:0] o_row, o_col;
    wire signed [PROD_W-1:0] o_product;
    wire [NORM_W-1:0] o_normalized;

    latin_square_square_normalizer_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall), .i_element(i_element),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_row(o_row), .o_col(o_col), .o_product(o_product),
        .o_normalized(o_normalized), .o_skipped(o_skipped), .o_last(o_last)
    );

    always #5 i_clk = ~i_clk;

    logic [LEN_W-1:0] len_reg;
    int unsigned loaded;
    logic signed [15:0] vec [8];
    t_cell cells_due[$];
    int errors = 0;
    int unsigned cycles = 0;
    bit calm = 1'b0;
    bit stop_rx = 1'b0;

    function automatic int unsigned used_length(logic [LEN_W-1:0] v);
        if (v == 0) return 1;
        if (v > 8) return 8;
        return v;
    endfunction

    // square the latin square from the loaded vector and queue every cell
    task automatic square_and_queue();
        int unsigned n;
        longint p [8][8];
        longint lo, hi, span;
        t_cell c;
        n = used_length(len_reg);
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++) begin
                p[i][j] = 0;
                for (int k = 0; k < n; k++)
                    p[i][j] += longint'(vec[(i+k)%n]) * longint'(vec[(k+j)%n]);
            end
        lo = p[0][0];
        hi = p[0][0];
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++) begin
                if (p[i][j] < lo) lo = p[i][j];
                if (p[i][j] > hi) hi = p[i][j];
            end
        span = hi - lo;
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++) begin
                c.row = IDX_W'(i);
                c.col = IDX_W'(j);
                c.product = PROD_W'(p[i][j]);
                c.skipped = (span == 0);
                c.normalized = (span == 0) ? '0 : NORM_W'(((p[i][j] - lo) << 15) / span);
                c.last = (i == n-1 && j == n-1);
                cells_due.push_back(c);
            end
    endtask

    task automatic load_element(logic signed [15:0] e);
        int unsigned n;
        n = used_length(len_reg);
        if (loaded >= n) loaded = 0;
        vec[loaded] = e;
        loaded++;
        if (loaded == n) begin
            loaded = 0;
            square_and_queue();
        end
    endtask

    task automatic send(logic signed [15:0] e);
        if (!calm && $urandom_range(99) < 37) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while (!calm && $urandom_range(99) < 37) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_element <= e;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        load_element(e);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (cells_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_length(logic [LEN_W-1:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        len_reg = v;
        loaded = 0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && !stop_rx)
            i_stall <= !calm && ($urandom_range(99) < 37);
    end

    always @(posedge i_clk) begin
        t_cell got, want;
        cycles++;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_row, o_col, o_product, o_normalized, o_skipped, o_last};
            if (cells_due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %p", got);
            end else begin
                want = cells_due.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
                end
            end
        end
        if (cycles > 2000000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    t_row directed [$];
    initial begin
        t_cell first;
        // length 1: single cell is the square of the element, always skipped
        directed.push_back('{4'd1, 1, 16'sh7fff, 1, 35'sd1073676289, 1});
        directed.push_back('{4'd0, 1, -16'sh8000, 1, 35'sd1073741824, 1});
        directed.push_back('{4'd15, 1, 16'sd0, 0, 0, 0});
        directed.push_back('{4'd0, 0, 16'sd0, 0, 0, 0});
        for (int k = 0; k < 5; k++) directed.push_back('{4'd0, 0, 16'sd0, 0, 0, 0});
        directed.push_back('{4'd0, 0, 16'sd0, 1, 35'sd0, 1}); // zeros at length 8
        directed.push_back('{4'd2, 1, -16'sh8000, 0, 0, 0});
        directed.push_back('{4'd0, 0, -16'sh8000, 1, 35'sd2147483648, 1});
        directed.push_back('{4'd3, 1, 16'sd1, 0, 0, 0});
        directed.push_back('{4'd0, 0, 16'sd256, 0, 0, 0});
        directed.push_back('{4'd5, 1, 16'sd7, 0, 0, 0}); // rewrite mid-load discards
        for (int k = 0; k < 4; k++) directed.push_back('{4'd0, 0, 16'sh7fff, 0, 0, 0});
        directed.push_back('{4'd4, 1, 16'sh7fff, 0, 0, 0});
        directed.push_back('{4'd0, 0, -16'sh8000, 0, 0, 0});
        directed.push_back('{4'd0, 0, 16'sh5555, 0, 0, 0});
        directed.push_back('{4'd0, 0, -16'sh5556, 0, 0, 0});

        len_reg = 8;
        loaded = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[r]) begin
            if (directed[r].do_len) write_length(directed[r].len);
            send(directed[r].elem);
            if (directed[r].known) begin
                first = cells_due[0];
                if (first.product !== directed[r].p00 || first.skipped !== directed[r].skip00) begin
                    errors++;
                    if (errors <= 10)
                        $display("directed row %0d: expected %0d/%0b got %0d/%0b", r,
                                 directed[r].p00, directed[r].skip00,
                                 first.product, first.skipped);
                end
            end
        end

        for (int it = 0; it < 400; it++) begin
            if (it % 40 == 0) write_length(LEN_W'($urandom_range(15)));
            if (it == 150) calm = 1'b1;
            if (it == 230) calm = 1'b0;
            if (it == 300) drain();
            case ($urandom_range(3))
                0: send(16'($urandom));
                1: send($urandom_range(1) ? 16'sh7fff : -16'sh8000);
                2: send(16'($urandom_range(600) - 300));
                default: send(16'sd128);
            endcase
        end

        fork
            drain();
            begin
                repeat (1500000) @(posedge i_clk);
            end
        join_any
        stop_rx = 1'b1;
        if (errors == 0 && cells_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
